// File: design/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared widths, constants and types for the sobel edge magnitude unit.
// ----------------------------------------------------------------------------
package sem_pkg;

   // image geometry
   localparam int MAX_WIDTH   = 1024;
   localparam int MIN_WIDTH   = 3;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WID_W       = $clog2(MAX_WIDTH + 1);

   // configuration register
   localparam int CFG_W       = 11;
   localparam int WIDTH_RESET = 640;

   // pixel and gradient widths
   localparam int PIX_W       = 8;
   localparam int SUM_W       = PIX_W + 2;
   localparam int GRAD_W      = SUM_W + 1;
   localparam int ABS_W       = SUM_W;
   localparam int SAT_LIMIT   = 255;

   // result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one line store entry: the two rows above the current one
   typedef struct packed {
      logic [PIX_W-1:0] upper;
      logic [PIX_W-1:0] middle;
   } line_word_type;

   // one window column, top to bottom
   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } column_type;

   // control carried with a beat down the pipeline
   typedef struct packed {
      logic valid;
      logic produce;
   } stage_ctl_type;

endpackage

// File: design/sem_line_store.sv
// ----------------------------------------------------------------------------
// sem_line_store
// Line store memory holding the two previous rows, one word per column,
// one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sem_line_store
   import sem_pkg::*;
(
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [COL_W-1:0]     rd_addr,
   output line_word_type        rd_data_ff,
   input  logic                 wr_en,
   input  logic [COL_W-1:0]     wr_addr,
   input  line_word_type        wr_data
);

   line_word_type mem [MAX_WIDTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// File: design/sem_gradient.sv
// ----------------------------------------------------------------------------
// sem_gradient
// Window column registers and the vertical and horizontal sobel terms,
// registered for the magnitude stage.
// ----------------------------------------------------------------------------
module sem_gradient
   import sem_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  stage_ctl_type               s1_ctl,
   input  column_type                  cur_col,
   output logic                        grad_valid_ff,
   output logic signed [GRAD_W-1:0]    vert_ff,
   output logic signed [GRAD_W-1:0]    horz_ff
);

   column_type left_ff, left_in;
   column_type centre_ff, centre_in;
   logic [SUM_W-1:0] sum_top, sum_bot, sum_left, sum_right;
   logic signed [GRAD_W-1:0] vert_in, horz_in;
   logic grad_valid_in;

   // weighted 1,2,1 sums over the window edges
   always_comb begin
      sum_top   = SUM_W'(left_ff.top) + {1'b0, centre_ff.top, 1'b0} + SUM_W'(cur_col.top);
      sum_bot   = SUM_W'(left_ff.bot) + {1'b0, centre_ff.bot, 1'b0} + SUM_W'(cur_col.bot);
      sum_left  = SUM_W'(left_ff.top) + {1'b0, left_ff.mid, 1'b0} + SUM_W'(left_ff.bot);
      sum_right = SUM_W'(cur_col.top) + {1'b0, cur_col.mid, 1'b0} + SUM_W'(cur_col.bot);
      vert_in   = $signed({1'b0, sum_top}) - $signed({1'b0, sum_bot});
      horz_in   = $signed({1'b0, sum_left}) - $signed({1'b0, sum_right});
   end

   // window shift on every beat
   always_comb begin
      left_in       = left_ff;
      centre_in     = centre_ff;
      grad_valid_in = s1_ctl.valid && s1_ctl.produce;
      if (s1_ctl.valid) begin
         left_in   = centre_ff;
         centre_in = cur_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         centre_ff     <= '0;
         grad_valid_ff <= 1'b0;
      end else begin
         left_ff       <= left_in;
         centre_ff     <= centre_in;
         grad_valid_ff <= grad_valid_in;
      end
   end

   // gradient terms
   always_ff @(posedge clock) begin
      vert_ff <= vert_in;
      horz_ff <= horz_in;
   end

endmodule

// File: design/sem_out_queue.sv
// ----------------------------------------------------------------------------
// sem_out_queue
// Magnitude and saturation of the gradient terms, then a small result
// queue that decouples the pipeline from the result channel.
// ----------------------------------------------------------------------------
module sem_out_queue
   import sem_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        grad_valid,
   input  logic signed [GRAD_W-1:0]    vert,
   input  logic signed [GRAD_W-1:0]    horz,
   output logic [QCNT_W-1:0]           count_ff,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [PIX_W-1:0]            rsp_edge_value
);

   logic [PIX_W-1:0] q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_in;
   logic [ABS_W-1:0] vert_abs, horz_abs;
   logic [ABS_W:0] mag_sum;
   logic [PIX_W-1:0] mag_sat;
   logic push, pop;

   // absolute values, sum and clamp
   always_comb begin
      vert_abs = vert[GRAD_W-1] ? ABS_W'(-vert) : ABS_W'(vert);
      horz_abs = horz[GRAD_W-1] ? ABS_W'(-horz) : ABS_W'(horz);
      mag_sum  = (ABS_W+1)'(vert_abs) + (ABS_W+1)'(horz_abs);
      if (32'(mag_sum) > SAT_LIMIT) begin
         mag_sat = PIX_W'(SAT_LIMIT);
      end else begin
         mag_sat = PIX_W'(mag_sum);
      end
   end

   // queue pointers and fill count
   assign push      = grad_valid;
   assign pop       = rsp_valid && rsp_ready;
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= mag_sat;
      end
   end

   // head of queue drives the result channel
   assign rsp_valid      = (count_ff != '0);
   assign rsp_edge_value = q_ff[rd_ptr_ff];

endmodule

// File: design/sobel_edge_magnitude_unit.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_unit
// Sobel 3x3 edge magnitude over a raster-order stream of 8-bit grey pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the queue has room and, for every pixel
// that completes a full 3x3 neighborhood, returns |vertical| + |horizontal|
// saturated at 255 for the pixel one row up and one column left; the first
// two rows and columns of a frame give no result. A beat with frame_start
// set restarts row and column counting. Row length comes from csr_line_width,
// clamped to 3..1024; the user must have it written only while the unit is
// idle, which the unit does not enforce. The two previous rows sit in one
// 1024-word line store memory that is read and written back once per pixel,
// so the sustained rate is one pixel per clock while the queue has room; a
// four-entry result queue lets input continue at full rate while the result
// channel stalls briefly. The line store needs no clearing after reset.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_unit
   import sem_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CFG_W-1:0]     csr_line_width,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIX_W-1:0]     req_pixel,
   input  logic                 req_frame_start,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PIX_W-1:0]     rsp_edge_value
);

   logic [CFG_W-1:0] width_ff;
   logic [WID_W-1:0] eff_width;
   logic [COL_W-1:0] col_ff, col_in, col_cur;
   logic [WID_W-1:0] col_inc;
   logic [1:0] row_ff, row_in, row_cur;
   logic accept, produce;

   stage_ctl_type s1_ctl_ff, s1_ctl_in;
   logic [COL_W-1:0] s1_addr_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic s1_fwd_ff;
   line_word_type s1_fwd_data_ff;
   line_word_type ls_rd_data, ls_word, ls_wr_data;
   logic fwd_hit;
   column_type cur_col;

   logic grad_valid;
   logic signed [GRAD_W-1:0] vert, horz;
   logic [QCNT_W-1:0] q_count;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= CFG_W'(WIDTH_RESET);
      end else if (csr_valid && csr_ready) begin
         width_ff <= csr_line_width;
      end
   end

   // clamp the row length to the supported range
   always_comb begin
      if (32'(width_ff) < MIN_WIDTH) begin
         eff_width = WID_W'(MIN_WIDTH);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_width = WID_W'(MAX_WIDTH);
      end else begin
         eff_width = WID_W'(width_ff);
      end
   end

   // input beat taken when queue plus in-flight results leave room
   assign req_ready = (32'(q_count) + 32'(s1_ctl_ff.valid) + 32'(grad_valid)) < QUEUE_DEPTH;
   assign accept    = req_valid && req_ready;

   // row and column position of the incoming pixel
   always_comb begin
      col_cur = req_frame_start ? '0 : col_ff;
      row_cur = req_frame_start ? '0 : row_ff;
      if (WID_W'(col_cur) >= eff_width) begin
         col_cur = '0;
      end
      produce = (row_cur == 2'd2) && (col_cur >= COL_W'(2));
      col_inc = WID_W'(col_cur) + 1'b1;
      col_in  = COL_W'(col_inc);
      row_in  = row_cur;
      if (col_inc >= eff_width) begin
         col_in = '0;
         if (row_cur != 2'd2) begin
            row_in = row_cur + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage one control: line store data arrives this stage
   always_comb begin
      s1_ctl_in.valid   = accept;
      s1_ctl_in.produce = produce;
   end

   // same column written back by the previous beat this cycle
   assign fwd_hit = s1_ctl_ff.valid && (s1_addr_ff == col_cur);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff     <= col_cur;
         s1_pix_ff      <= req_pixel;
         s1_fwd_ff      <= fwd_hit;
         s1_fwd_data_ff <= ls_wr_data;
      end
   end

   // resolve read data and write the rows back shifted up by one
   assign ls_word          = s1_fwd_ff ? s1_fwd_data_ff : ls_rd_data;
   assign ls_wr_data.upper  = ls_word.middle;
   assign ls_wr_data.middle = s1_pix_ff;

   assign cur_col.top = ls_word.upper;
   assign cur_col.mid = ls_word.middle;
   assign cur_col.bot = s1_pix_ff;

   sem_line_store u_line_store (
      .clock      (clock),
      .rd_en      (accept),
      .rd_addr    (col_cur),
      .rd_data_ff (ls_rd_data),
      .wr_en      (s1_ctl_ff.valid),
      .wr_addr    (s1_addr_ff),
      .wr_data    (ls_wr_data)
   );

   sem_gradient u_gradient (
      .clock         (clock),
      .reset         (reset),
      .s1_ctl        (s1_ctl_ff),
      .cur_col       (cur_col),
      .grad_valid_ff (grad_valid),
      .vert_ff       (vert),
      .horz_ff       (horz)
   );

   sem_out_queue u_out_queue (
      .clock          (clock),
      .reset          (reset),
      .grad_valid     (grad_valid),
      .vert           (vert),
      .horz           (horz),
      .count_ff       (q_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_edge_value (rsp_edge_value)
   );

endmodule

// File: design/sem_checker.sv
// ----------------------------------------------------------------------------
// sem_checker
// Port-level checks for the sobel edge magnitude unit, bound to the top.
// ----------------------------------------------------------------------------
module sem_checker
   import sem_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic                 req_ready,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [PIX_W-1:0]     rsp_edge_value
);

   // a stalled result beat holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_edge_value))
      else $error("result beat changed while stalled");

   // reset empties the result side
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending right after reset");

   // input back pressure only comes from results waiting downstream
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result waiting");

   // configuration writes are never stalled
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration beat stalled");

endmodule

bind sobel_edge_magnitude_unit sem_checker u_sem_checker (.*);

// File: dv/sobel_edge_checker.sv
// ----------------------------------------------------------------------------
// sobel_edge_checker
// Watches the pixel, result and register channels of the sobel edge unit,
// keeps its own line stores and window, predicts every edge value and
// compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module sobel_edge_checker
   import sem_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [CFG_W-1:0] csr_line_width,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [PIX_W-1:0] req_pixel,
   input  logic             req_frame_start,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [PIX_W-1:0] rsp_edge_value,
   input  logic             end_check,
   output int               mismatch_count,
   output int               edges_waiting,
   output int               edges_checked
);

   // shadow copy of the unit's state
   logic [PIX_W-1:0] upper_row [MAX_WIDTH];
   logic [PIX_W-1:0] middle_row [MAX_WIDTH];
   column_type       left_col;
   column_type       centre_col;
   int unsigned      col_idx;
   int unsigned      row_idx;
   logic [CFG_W-1:0] width_reg;

   // edge values predicted but not yet seen on rsp
   logic [PIX_W-1:0] expected_edges [$];
   bit               leftovers_done;

   // register value to row length, clamped to the supported range
   function automatic int unsigned row_length(input logic [CFG_W-1:0] w);
      if (w < MIN_WIDTH) return MIN_WIDTH;
      if (w > MAX_WIDTH) return MAX_WIDTH;
      return w;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("[%0t] edge check: %s", $time, what);
      mismatch_count++;
   endtask

   // take one pixel into the window, queue an edge value if the window is full
   task automatic step_window(input logic [PIX_W-1:0] pix, input logic restart);
      int unsigned len;
      column_type  cur;
      int          vert;
      int          horz;
      int          mag;
      len = row_length(width_reg);
      if (restart) begin
         col_idx = 0;
         row_idx = 0;
      end
      if (col_idx >= len) col_idx = 0;

      // read the two rows above and shift the column down
      cur.top = upper_row[col_idx];
      cur.mid = middle_row[col_idx];
      cur.bot = pix;
      upper_row[col_idx]  = cur.mid;
      middle_row[col_idx] = pix;

      // interior pixels only: two full rows and two columns behind
      if (row_idx >= 2 && col_idx >= 2) begin
         vert = (int'(left_col.top) + 2 * int'(centre_col.top) + int'(cur.top))
              - (int'(left_col.bot) + 2 * int'(centre_col.bot) + int'(cur.bot));
         horz = (int'(left_col.top) - int'(cur.top))
              + 2 * (int'(left_col.mid) - int'(cur.mid))
              + (int'(left_col.bot) - int'(cur.bot));
         mag  = ((vert < 0) ? -vert : vert) + ((horz < 0) ? -horz : horz);
         if (mag > SAT_LIMIT) mag = SAT_LIMIT;
         expected_edges.push_back(mag[PIX_W-1:0]);
      end

      left_col   = centre_col;
      centre_col = cur;

      // column and row counting, row count stops at two
      col_idx++;
      if (col_idx >= len) begin
         col_idx = 0;
         if (row_idx < 2) row_idx++;
      end
   endtask

   // sample all channels at the rising edge
   always @(posedge clock) begin : watch
      logic [PIX_W-1:0] want;
      if (reset) begin
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
         end
         left_col       = '0;
         centre_col     = '0;
         col_idx        = 0;
         row_idx        = 0;
         width_reg      = CFG_W'(WIDTH_RESET);
         leftovers_done = 1'b0;
         expected_edges.delete();
      end else begin
         if (csr_valid && csr_ready) width_reg = csr_line_width;
         if (req_valid && req_ready) step_window(req_pixel, req_frame_start);

         // result beat against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_edges.size() == 0) begin
               flag_mismatch($sformatf("edge value %0d with nothing expected",
                                       rsp_edge_value));
            end else begin
               want = expected_edges.pop_front();
               if (rsp_edge_value !== want)
                  flag_mismatch($sformatf("edge value %0d, expected %0d",
                                          rsp_edge_value, want));
               edges_checked++;
            end
         end

         // predictions still waiting at the end of the run
         if (end_check && !leftovers_done) begin
            leftovers_done = 1'b1;
            if (expected_edges.size() != 0)
               flag_mismatch($sformatf("%0d expected edge values never arrived",
                                       expected_edges.size()));
         end
      end
      edges_waiting = expected_edges.size();
   end

endmodule

// File: dv/tb_sobel_edge_magnitude_unit.sv
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude_unit
// Stimulus and verdict for the sobel edge magnitude unit.
// ----------------------------------------------------------------------------
// Drives a short hand-built pair of frames at row width three (flat, fully
// saturated and small gradients, a mid-row restart), then frames of random,
// extreme, ramped and flat pixels over many row widths, clamped ones
// included. Idling on both channels changes over the run, the result side
// is held off once long enough to back up the input, and every width change
// happens with the unit drained. The checker beside the unit does all
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_unit
   import sem_pkg::*;
();

   typedef enum int {PAT_NOISE, PAT_EXTREME, PAT_RAMP, PAT_FLAT} pixel_pattern_type;

   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int SHORT_FRAME   = 40;
   localparam int PHASE_BUDGET  = 40;
   localparam int NUM_PHASES    = 18;
   localparam int NUM_DIRECTED  = 26;
   localparam logic [NUM_DIRECTED-1:0] DIRECTED_SOF = NUM_DIRECTED'((1 << 0) | (1 << 17));

   logic             clock;
   logic             reset;
   logic             csr_valid;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_line_width;
   logic             req_valid;
   logic             req_ready;
   logic [PIX_W-1:0] req_pixel;
   logic             req_frame_start;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [PIX_W-1:0] rsp_edge_value;

   logic             end_check;
   int               mismatch_count;
   int               edges_waiting;
   int               edges_checked;

   int               send_idle_pct;
   int               recv_idle_pct;
   int               pixels_sent;
   int               phases_run;
   bit               hold_request;

   // flat frame, full vertical step, mixed step, restart, small gradient
   int directed_pix [NUM_DIRECTED] = '{
      0, 0, 0,   0, 0, 0,   0, 0, 0,   255, 255, 255,   255, 0, 0,
      17, 200,
      3, 0, 0,   3, 0, 0,   3, 0, 1
   };

   // row widths written over the run, clamped and extreme values among them
   logic [CFG_W-1:0] phase_widths [NUM_PHASES] = '{
      3, 0, 1, 2, 4, 5, 2047, 7, 11, 1024, 3, 1025, 33, 64, 6, 9, 3, 4
   };

   sobel_edge_magnitude_unit dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_line_width  (csr_line_width),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_edge_value  (rsp_edge_value)
   );

   sobel_edge_checker edge_check (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_line_width  (csr_line_width),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_edge_value  (rsp_edge_value),
      .end_check       (end_check),
      .mismatch_count  (mismatch_count),
      .edges_waiting   (edges_waiting),
      .edges_checked   (edges_checked)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #10000000;
      $display("simulation failed");
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic [PIX_W-1:0] shape_pixel(input pixel_pattern_type kind,
                                                    input int base, input int col,
                                                    input int row);
      case (kind)
         PAT_EXTREME: return ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
         PAT_RAMP:    return PIX_W'(base + 3 * col + 5 * row);
         PAT_FLAT:    return PIX_W'(base + $urandom_range(3));
         default:     return PIX_W'($urandom);
      endcase
   endfunction

   // one pixel beat, idling first; returns at the falling edge after acceptance
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof);
      if (pixels_sent < 430) begin
         send_idle_pct = 19;
         recv_idle_pct = 54;
      end else if (pixels_sent < 870) begin
         send_idle_pct = 54;
         recv_idle_pct = 19;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel       <= pix;
      req_frame_start <= sof;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      pixels_sent++;
   endtask

   // register write beat, only with the unit idle
   task automatic write_width(input logic [CFG_W-1:0] value);
      csr_valid      <= 1'b1;
      csr_line_width <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      phases_run++;
   endtask

   // stop sending until every predicted edge value has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (edges_waiting != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one frame in raster order, with the odd restart inside it
   task automatic send_frame(input int len, input int pixel_count);
      pixel_pattern_type kind;
      int                base;
      kind = pixel_pattern_type'($urandom_range(3));
      base = $urandom_range(255);
      for (int i = 0; i < pixel_count; i++)
         send_pixel(shape_pixel(kind, base, i % len, i / len),
                    (i == 0) || (len < MAX_WIDTH && $urandom_range(99) == 0));
   endtask

   // drain, set a width, then frames at that width
   task automatic run_phase(input logic [CFG_W-1:0] reg_value);
      int len;
      int rows;
      int count;
      int sent;
      len = (reg_value < MIN_WIDTH) ? MIN_WIDTH :
            (reg_value > MAX_WIDTH) ? MAX_WIDTH : reg_value;
      wait_drained();
      write_width(reg_value);
      if (len == MAX_WIDTH) begin
         // widest rows: one short frame for clamping and column counting
         send_frame(len, SHORT_FRAME);
      end else begin
         sent = 0;
         while (sent < PHASE_BUDGET) begin
            rows  = (len > 32) ? 3 : $urandom_range(3, 6);
            count = len * rows;
            if ($urandom_range(9) == 0) count = $urandom_range(1, count - 1);
            send_frame(len, count);
            sent += count;
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      reset           = 1'b1;
      csr_valid       = 1'b0;
      csr_line_width  = '0;
      req_valid       = 1'b0;
      req_pixel       = '0;
      req_frame_start = 1'b0;
      end_check       = 1'b0;
      hold_request    = 1'b0;
      pixels_sent     = 0;
      phases_run      = 0;
      send_idle_pct   = 19;
      recv_idle_pct   = 54;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // hand-built frames at the narrowest width
      write_width(CFG_W'(MIN_WIDTH));
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_pixel(PIX_W'(directed_pix[i]), DIRECTED_SOF[i]);

      // long result hold-off while pixels keep coming
      req_valid <= 1'b0;
      @(posedge clock);
      hold_request = 1'b1;
      @(negedge clock);
      send_frame(MIN_WIDTH, 60);

      // random frames over the width list, then a few random widths
      for (int p = 0; p < NUM_PHASES; p++)
         run_phase(phase_widths[p]);
      for (int p = 0; p < 3; p++)
         run_phase(CFG_W'($urandom_range(3, 40)));

      wait_drained();
      end_check = 1'b1;
      repeat (2) @(negedge clock);

      $display("checked %0d edge values from %0d pixels over %0d row width settings",
               edges_checked, pixels_sent, phases_run);
      $display("run covered borders, saturation, restarts, clamped widths, a long stall");
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
